// File: src/tga_rle_pixel_decoder_macros.svh
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_macros.svh
// Assertion macros shared by the decoder's checker.
// ----------------------------------------------------------------------------
`ifndef TGA_RLE_PIXEL_DECODER_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_MACROS_SVH

// property checked on each rising edge outside reset
`define TRPD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked on each rising edge, reset included
`define TRPD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: src/trpd_pkg.sv
// ----------------------------------------------------------------------------
// trpd_pkg
// Types and constants shared by the TGA run-length pixel decoder.
// ----------------------------------------------------------------------------
package trpd_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_BYTES_PER_PIXEL = 2'd0,
    CFG_COMPRESSED_MODE = 2'd1,
    CFG_IMAGE_PIXELS    = 2'd2
  } cfg_idx_e;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] REPEAT_BIT    = 8'h80;
  localparam logic [2:0] BPP_32BIT     = 3'd4;
  localparam logic [1:0] LAST_IDX_32   = 2'd3;
  localparam logic [1:0] LAST_IDX_24   = 2'd2;
  localparam logic [1:0] COPIES_ONE    = 2'd1;
  localparam logic [1:0] COPIES_TWO    = 2'd2;

  // configuration as seen by the front end
  typedef struct packed {
    logic [2:0]  bytes_per_pixel;
    logic        compressed_mode;
    logic [31:0] image_pixels;
  } cfg_t;

  // one pixel job: a pixel and how many copies of it to send
  typedef struct packed {
    logic [31:0] pix;
    logic [7:0]  count;
    logic        last;
  } job_t;

endpackage

// File: src/trpd_fifo.sv
// ----------------------------------------------------------------------------
// trpd_fifo
// Small job queue between the byte front end and the pixel back end.
// ----------------------------------------------------------------------------
module trpd_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  trpd_pkg::job_t  push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output trpd_pkg::job_t  pop_data_o
);
  import trpd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  // handshake and pointer update
  always_comb begin
    push_ready_o = (cnt_q != Full);
    pop_valid_o  = (cnt_q != '0);
    pop_data_o   = mem_q[rd_ptr_q];
    do_push      = push_valid_i && push_ready_o;
    do_pop       = pop_valid_o && pop_ready_i;
    wr_ptr_d     = wr_ptr_q;
    rd_ptr_d     = rd_ptr_q;
    cnt_d        = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // job storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: src/trpd_front.sv
// ----------------------------------------------------------------------------
// trpd_front
// Takes data bytes, parses packet headers, assembles pixels and clips each
// pixel's copy count to what the image still owes.
// ----------------------------------------------------------------------------
module trpd_front #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  trpd_pkg::cfg_t  cfg_i,
  input  logic            byte_valid_i,
  output logic            byte_ready_o,
  input  logic [7:0]      byte_i,
  input  logic            sof_i,
  output logic            job_valid_o,
  input  logic            job_ready_i,
  output trpd_pkg::job_t  job_o
);
  import trpd_pkg::*;

  logic [31:0]             asm_q, asm_d, asm_e, asm_new;
  logic [1:0]              bip_q, bip_d, bip_e, last_idx;
  logic                    await_q, await_d, await_e;
  logic                    rep_q, rep_d, rep_e;
  logic [7:0]              left_q, left_d, left_e;
  logic [COUNT_WIDTH-1:0]  emitted_q, emitted_d, emitted_e;
  logic                    fin_q, fin_d, fin_e;
  logic [COUNT_WIDTH+31:0] target_ext;
  logic [COUNT_WIDTH-1:0]  target, owed;
  logic                    accept, clr, img_idle;
  logic [7:0]              want, n;

  assign byte_ready_o = job_ready_i;
  assign accept       = byte_valid_i && byte_ready_o;
  assign clr          = accept && sof_i;

  // state as seen by this byte, after an optional start-of-image clear
  always_comb begin
    asm_e     = clr ? '0 : asm_q;
    bip_e     = clr ? '0 : bip_q;
    await_e   = clr ? 1'b1 : await_q;
    rep_e     = clr ? 1'b0 : rep_q;
    left_e    = clr ? '0 : left_q;
    emitted_e = clr ? '0 : emitted_q;
    fin_e     = clr ? 1'b0 : fin_q;
  end

  // pixel target, remaining pixels and byte insertion
  always_comb begin
    target_ext = {{COUNT_WIDTH{1'b0}}, cfg_i.image_pixels};
    target     = target_ext[COUNT_WIDTH-1:0];
    owed       = target - emitted_e;
    img_idle   = fin_e || (emitted_e >= target);
    last_idx   = (cfg_i.bytes_per_pixel == BPP_32BIT) ? LAST_IDX_32 : LAST_IDX_24;
    asm_new    = asm_e;
    case (bip_e)
      2'd0:    asm_new[7:0]   = byte_i;
      2'd1:    asm_new[15:8]  = byte_i;
      2'd2:    asm_new[23:16] = byte_i;
      default: asm_new[31:24] = byte_i;
    endcase
    want = (cfg_i.compressed_mode && rep_e) ? left_e : 8'd1;
    n    = (owed < COUNT_WIDTH'(want)) ? owed[7:0] : want;
  end

  // packet and pixel state update
  always_comb begin
    asm_d       = asm_q;
    bip_d       = bip_q;
    await_d     = await_q;
    rep_d       = rep_q;
    left_d      = left_q;
    emitted_d   = emitted_q;
    fin_d       = fin_q;
    job_valid_o = 1'b0;
    job_o.pix   = {(cfg_i.bytes_per_pixel == BPP_32BIT) ? asm_new[31:24] : 8'h00,
                   asm_new[23:0]};
    job_o.count = n;
    job_o.last  = (owed == COUNT_WIDTH'(n));
    if (accept) begin
      asm_d     = asm_e;
      bip_d     = bip_e;
      await_d   = await_e;
      rep_d     = rep_e;
      left_d    = left_e;
      emitted_d = emitted_e;
      fin_d     = fin_e;
      if (!img_idle) begin
        if (cfg_i.compressed_mode && await_e) begin
          // packet header byte
          rep_d   = (byte_i & REPEAT_BIT) != 8'h00;
          left_d  = {1'b0, byte_i[6:0]} + 8'd1;
          await_d = 1'b0;
        end else if (bip_e < last_idx) begin
          asm_d = asm_new;
          bip_d = bip_e + 2'd1;
        end else begin
          // pixel complete
          asm_d       = '0;
          bip_d       = '0;
          job_valid_o = (n != 8'd0);
          emitted_d   = emitted_e + COUNT_WIDTH'(n);
          if ((n != 8'd0) && (owed == COUNT_WIDTH'(n))) begin
            fin_d = 1'b1;
          end
          if (cfg_i.compressed_mode) begin
            if (rep_e) begin
              left_d  = '0;
              await_d = 1'b1;
            end else begin
              left_d  = left_e - 8'd1;
              await_d = (left_e == 8'd1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asm_q     <= '0;
      bip_q     <= '0;
      await_q   <= 1'b1;
      rep_q     <= 1'b0;
      left_q    <= '0;
      emitted_q <= '0;
      fin_q     <= 1'b0;
    end else begin
      asm_q     <= asm_d;
      bip_q     <= bip_d;
      await_q   <= await_d;
      rep_q     <= rep_d;
      left_q    <= left_d;
      emitted_q <= emitted_d;
      fin_q     <= fin_d;
    end
  end

endmodule

// File: src/trpd_back.sv
// ----------------------------------------------------------------------------
// trpd_back
// Drains pixel jobs into output items of one or two copies each.
// ----------------------------------------------------------------------------
module trpd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  output logic            job_ready_o,
  input  trpd_pkg::job_t  job_i,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [39:0]     m_axis_tdata,
  output logic            m_axis_tlast
);
  import trpd_pkg::*;

  logic        cur_valid_q, cur_valid_d;
  job_t        cur_q, cur_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_pix_q;
  logic [1:0]  out_copies_q, copies;
  logic        out_last_q;
  logic        out_free, emit, cur_fin, pop;

  // chunking of the current job
  always_comb begin
    out_free    = !out_valid_q || m_axis_tready;
    emit        = cur_valid_q && out_free;
    copies      = (cur_q.count >= 8'd2) ? COPIES_TWO : COPIES_ONE;
    cur_fin     = emit && (cur_q.count <= 8'd2);
    job_ready_o = !cur_valid_q || cur_fin;
    pop         = job_valid_i && job_ready_o;
    cur_valid_d = cur_valid_q;
    cur_d       = cur_q;
    if (pop) begin
      cur_valid_d = 1'b1;
      cur_d       = job_i;
    end else if (cur_fin) begin
      cur_valid_d = 1'b0;
    end else if (emit) begin
      cur_d.count = cur_q.count - {6'd0, copies};
    end
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // job and output item payload
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (emit) begin
      out_pix_q    <= cur_q.pix;
      out_copies_q <= copies;
      out_last_q   <= cur_fin && cur_q.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_copies_q, out_pix_q};
  assign m_axis_tlast  = out_last_q;

endmodule

// File: src/tga_rle_pixel_decoder.sv
// A completed pixel crosses the job queue, the back end's job register and output register.
// Throughput: one byte per cycle while the two-entry job queue has room.
// The back end sends a pixel of n copies as ceil(n/2) items, one per cycle unless stalled.
// Bytes stall only when the job queue fills, as on long repeat runs or a stalled output.
// Reset: asynchronous, active low; clears packet state, counters and queue at once.
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// TGA pixel-data decoder for uncompressed and run-length encoded images.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // byte stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tuser,   // [0] start_of_image
  // pixel items out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] chan0, [15:8] chan1, [23:16] chan2,
                                      // [31:24] chan3, [33:32] copies, zero pad
  output logic        m_axis_tlast    // image_done
);
  import trpd_pkg::*;

  cfg_t cfg_q;
  logic fq_push_valid, fq_push_ready, fq_pop_valid, fq_pop_ready;
  job_t fq_push_data, fq_pop_data;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bytes_per_pixel <= 3'd3;
      cfg_q.compressed_mode <= 1'b1;
      cfg_q.image_pixels    <= 32'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_BYTES_PER_PIXEL: cfg_q.bytes_per_pixel <= cfg_data_i[2:0];
        CFG_COMPRESSED_MODE: cfg_q.compressed_mode <= cfg_data_i[0];
        CFG_IMAGE_PIXELS:    cfg_q.image_pixels    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  trpd_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_o (s_axis_tready),
    .byte_i       (s_axis_tdata),
    .sof_i        (s_axis_tuser),
    .job_valid_o  (fq_push_valid),
    .job_ready_i  (fq_push_ready),
    .job_o        (fq_push_data)
  );

  trpd_fifo #(
    .Depth(QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_push_valid),
    .push_ready_o (fq_push_ready),
    .push_data_i  (fq_push_data),
    .pop_valid_o  (fq_pop_valid),
    .pop_ready_i  (fq_pop_ready),
    .pop_data_o   (fq_pop_data)
  );

  trpd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (fq_pop_valid),
    .job_ready_o   (fq_pop_ready),
    .job_i         (fq_pop_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// File: src/trpd_checker.sv
// ----------------------------------------------------------------------------
// trpd_checker
// Port-level checks on the decoder's output stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "tga_rle_pixel_decoder_macros.svh"

module trpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // an item stands for one or two pixels
  `TRPD_ASSERT(a_copies_range, m_axis_tvalid |-> (m_axis_tdata[33:32] == 2'd1 || m_axis_tdata[33:32] == 2'd2), "copies out of range")

  // pad bits stay zero
  `TRPD_ASSERT(a_pad_zero, m_axis_tvalid |-> (m_axis_tdata[39:34] == 6'd0), "tdata pad bits set")

  // a stalled item holds with its frame mark
  `TRPD_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output item changed while stalled")

  // a reset edge empties the output register
  `TRPD_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !m_axis_tvalid, "output valid after reset")

endmodule

bind tga_rle_pixel_decoder trpd_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
